// ----- rtl/core/cdtd_pkg.sv -----
// Package for the countdown timer with digit display.
// Holds the item and result beat types, widths and the timer constants.
// No dependencies.
`timescale 1ns / 1ps

package cdtd_pkg;

  localparam int unsigned TimeW  = 14;
  localparam int unsigned BuzzW  = 6;
  localparam int unsigned DigitW = 4;

  localparam logic [TimeW-1:0] TimeCap     = 14'd9990;
  localparam logic [TimeW-1:0] StepOneMax  = 14'd600;
  localparam logic [TimeW-1:0] StepTwoMax  = 14'd2400;
  localparam logic [TimeW-1:0] StepOne     = 14'd100;
  localparam logic [TimeW-1:0] StepTwo     = 14'd200;
  localparam logic [TimeW-1:0] StepThree   = 14'd300;
  localparam logic [TimeW-1:0] TenthsLimit = 14'd100;
  localparam logic [TimeW-1:0] DotLimit    = 14'd1000;

  localparam logic [BuzzW-1:0]  BuzzDefault = 6'd50;
  localparam logic [DigitW-1:0] BlankDigit  = 4'd10;

  localparam logic ModeTick = 1'b0;
  localparam logic ModeAdd  = 1'b1;

  typedef struct packed {
    logic mode;
    logic run_enable;
  } in_beat_t;

  typedef struct packed {
    logic [DigitW-1:0] digit_high;
    logic [DigitW-1:0] digit_mid;
    logic [DigitW-1:0] digit_low;
    logic              dot_on_low;
    logic              buzzer_on;
    logic [TimeW-1:0]  time_left;
  } out_beat_t;

endpackage

// ----- rtl/core/countdown_timer_with_digit_display_unit.sv -----
// Top level of the countdown timer with digit display.
// Depends on cdtd_pkg for beat types and constants.
`timescale 1ns / 1ps

// Usage:
// Input beats arrive on in_valid_i / in_data_i and are taken at a rising edge
// with in_valid_i high and in_stall_o low. Each beat is either a timer tick or
// an add-time press and yields exactly one result beat on out_valid_o /
// out_data_o, taken when out_stall_i is low.
// The timer state is updated in the accepting cycle and the result register
// is loaded at the same edge, so a result appears in the cycle after its input is taken.
// One item is accepted in every cycle while in_stall_o is low; the single result register sets this
// figure, and the display digits are derived from it by constant multiplies.
// While the receiver stalls, the result holds and in_stall_o rises only if a
// result is waiting and out_stall_i is high, so a new beat enters as soon as
// the waiting one is taken.
// The buzz length register is written over cfg_valid_i / cfg_data_i and is
// always ready. Reset clears the time and the buzzer state, empties the result
// register, and sets the buzz length to fifty ticks.
module countdown_timer_with_digit_display_unit (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  cdtd_pkg::in_beat_t         in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output cdtd_pkg::out_beat_t        out_data_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [cdtd_pkg::BuzzW-1:0] cfg_data_i
);

  logic [cdtd_pkg::BuzzW-1:0] buzz_ticks_q;
  logic [cdtd_pkg::TimeW-1:0] time_q, time_d;
  logic [cdtd_pkg::BuzzW-1:0] cnt_q, cnt_d;
  logic                       armed_q, armed_d;
  logic                       buzzer_q, buzzer_d;
  logic [cdtd_pkg::TimeW-1:0] added;
  logic [cdtd_pkg::TimeW-1:0] show_d;

  logic                       out_valid_q;
  logic [cdtd_pkg::TimeW-1:0] show_q;
  logic                       res_buzzer_q;
  logic [cdtd_pkg::TimeW-1:0] res_time_q;

  logic                       in_accept;

  logic [27:0]                prod10, prod100, prod1000;
  logic [9:0]                 q10;
  logic [6:0]                 q100;
  logic [3:0]                 q1000;
  logic [cdtd_pkg::TimeW-1:0] rem1;
  logic [9:0]                 rem10;
  logic [6:0]                 rem100;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    if (time_q <= cdtd_pkg::StepOneMax) begin
      added = time_q + cdtd_pkg::StepOne;
    end else if (time_q <= cdtd_pkg::StepTwoMax) begin
      added = time_q + cdtd_pkg::StepTwo;
    end else begin
      added = time_q + cdtd_pkg::StepThree;
    end
    if (added > cdtd_pkg::TimeCap) begin
      added = cdtd_pkg::TimeCap;
    end

    time_d   = time_q;
    cnt_d    = cnt_q;
    armed_d  = armed_q;
    buzzer_d = buzzer_q;
    show_d   = time_q;

    if (in_data_i.mode == cdtd_pkg::ModeAdd) begin
      time_d = added;
      show_d = added;
    end else if (in_data_i.run_enable) begin
      if (time_q != '0) begin
        time_d = time_q - 14'd1;
      end else if (!armed_q) begin
        buzzer_d = 1'b1;
        cnt_d    = buzz_ticks_q;
        armed_d  = 1'b1;
      end
      if (armed_d) begin
        if (cnt_d != '0) begin
          cnt_d = cnt_d - 6'd1;
        end else begin
          buzzer_d = 1'b0;
        end
      end
    end else begin
      armed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buzz_ticks_q <= cdtd_pkg::BuzzDefault;
      time_q       <= '0;
      cnt_q        <= '0;
      armed_q      <= 1'b0;
      buzzer_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        buzz_ticks_q <= cfg_data_i;
      end
      if (in_accept) begin
        time_q      <= time_d;
        cnt_q       <= cnt_d;
        armed_q     <= armed_d;
        buzzer_q    <= buzzer_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      show_q       <= show_d;
      res_buzzer_q <= buzzer_d;
      res_time_q   <= time_d;
    end
  end

  // Reciprocal multiplies are exact for every value up to the cap.
  assign prod10   = 28'(show_q) * 28'd6554;
  assign prod100  = 28'(show_q) * 28'd5243;
  assign prod1000 = 28'(show_q) * 28'd8389;
  assign q10      = prod10[25:16];
  assign q100     = prod100[25:19];
  assign q1000    = prod1000[26:23];
  assign rem1     = show_q - ((14'(q10) << 3) + (14'(q10) << 1));
  assign rem10    = q10 - ((10'(q100) << 3) + (10'(q100) << 1));
  assign rem100   = q100 - ((7'(q1000) << 3) + (7'(q1000) << 1));

  always_comb begin
    out_data_o.buzzer_on = res_buzzer_q;
    out_data_o.time_left = res_time_q;
    if (show_q < cdtd_pkg::TenthsLimit) begin
      out_data_o.digit_high = cdtd_pkg::BlankDigit;
      out_data_o.digit_mid  = rem10[3:0];
      out_data_o.digit_low  = rem1[3:0];
      out_data_o.dot_on_low = 1'b1;
    end else if (show_q < cdtd_pkg::DotLimit) begin
      out_data_o.digit_high = rem100[3:0];
      out_data_o.digit_mid  = rem10[3:0];
      out_data_o.digit_low  = rem1[3:0];
      out_data_o.dot_on_low = 1'b1;
    end else begin
      out_data_o.digit_high = q1000;
      out_data_o.digit_mid  = rem100[3:0];
      out_data_o.digit_low  = rem10[3:0];
      out_data_o.dot_on_low = 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q <= cdtd_pkg::TimeCap)
    else $error("Remaining time above the cap.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.mode == cdtd_pkg::ModeAdd) |=>
      (out_valid_q && time_q != '0 && res_time_q == time_q))
    else $error("Add-time beat did not raise the time.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && in_data_i.mode == cdtd_pkg::ModeTick && in_data_i.run_enable &&
     time_q != '0) |=> (time_q == $past(time_q) - 14'd1 && show_q == $past(time_q)))
    else $error("Running tick did not count down by one.");

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for countdown_timer_with_digit_display_unit.
// A scoreboard class predicts every result beat from the accepted item beats.
// Depends on cdtd_pkg and the top level of the timer.
`timescale 1ns / 1ps

module testbench;

  class countdown_predictor;
    logic [cdtd_pkg::TimeW-1:0] remaining;
    logic [cdtd_pkg::BuzzW-1:0] buzz_left;
    logic [cdtd_pkg::BuzzW-1:0] buzz_len;
    bit armed;
    bit buzzing;
    cdtd_pkg::out_beat_t expected_beats[$];
    int failures;

    function new();
      remaining = '0;
      buzz_left = '0;
      buzz_len = cdtd_pkg::BuzzDefault;
      armed = 1'b0;
      buzzing = 1'b0;
      failures = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function int time_now();
      return remaining;
    endfunction

    function void set_buzz_len(logic [cdtd_pkg::BuzzW-1:0] v);
      buzz_len = v;
    endfunction

    function cdtd_pkg::out_beat_t display_of(int t);
      cdtd_pkg::out_beat_t r;
      r = '0;
      if (t < cdtd_pkg::TenthsLimit) begin
        r.digit_high = cdtd_pkg::BlankDigit;
        r.digit_mid = 4'((t / 10) % 10);
        r.digit_low = 4'(t % 10);
        r.dot_on_low = 1'b1;
      end else if (t < cdtd_pkg::DotLimit) begin
        r.digit_high = 4'((t / 100) % 10);
        r.digit_mid = 4'((t / 10) % 10);
        r.digit_low = 4'(t % 10);
        r.dot_on_low = 1'b1;
      end else begin
        r.digit_high = 4'((t / 1000) % 10);
        r.digit_mid = 4'((t / 100) % 10);
        r.digit_low = 4'((t / 10) % 10);
        r.dot_on_low = 1'b0;
      end
      return r;
    endfunction

    function void note_item(cdtd_pkg::in_beat_t b);
      cdtd_pkg::out_beat_t r;
      int t;
      t = remaining;
      if (b.mode == cdtd_pkg::ModeAdd) begin
        if (t <= cdtd_pkg::StepOneMax) begin
          t += cdtd_pkg::StepOne;
        end else if (t <= cdtd_pkg::StepTwoMax) begin
          t += cdtd_pkg::StepTwo;
        end else begin
          t += cdtd_pkg::StepThree;
        end
        if (t > cdtd_pkg::TimeCap) begin
          t = cdtd_pkg::TimeCap;
        end
        remaining = t[cdtd_pkg::TimeW-1:0];
        r = display_of(t);
      end else begin
        r = display_of(t);
        if (b.run_enable) begin
          if (remaining != 0) begin
            remaining = remaining - 1'b1;
          end else if (!armed) begin
            buzzing = 1'b1;
            buzz_left = buzz_len;
            armed = 1'b1;
          end
          if (armed) begin
            if (buzz_left != 0) begin
              buzz_left = buzz_left - 1'b1;
            end else begin
              buzzing = 1'b0;
            end
          end
        end else begin
          armed = 1'b0;
        end
      end
      r.buzzer_on = buzzing;
      r.time_left = remaining;
      expected_beats.push_back(r);
    endfunction

    function void compare(string name, logic [cdtd_pkg::TimeW-1:0] want,
                          logic [cdtd_pkg::TimeW-1:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(cdtd_pkg::out_beat_t got);
      cdtd_pkg::out_beat_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with no item waiting: %p", got);
        failures++;
        return;
      end
      want = expected_beats.pop_front();
      compare("digit_high", 14'(want.digit_high), 14'(got.digit_high));
      compare("digit_mid", 14'(want.digit_mid), 14'(got.digit_mid));
      compare("digit_low", 14'(want.digit_low), 14'(got.digit_low));
      compare("dot_on_low", 14'(want.dot_on_low), 14'(got.dot_on_low));
      compare("buzzer_on", 14'(want.buzzer_on), 14'(got.buzzer_on));
      compare("time_left", want.time_left, got.time_left);
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  cdtd_pkg::in_beat_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  cdtd_pkg::out_beat_t out_data_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [cdtd_pkg::BuzzW-1:0] cfg_data_i = '0;

  countdown_predictor model;
  bit calm = 1'b0;
  bit hold_out = 1'b0;
  int items_sent = 0;

  countdown_timer_with_digit_display_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        model.check_result(out_data_o);
      end
      if (in_valid_i && !in_stall_o) begin
        model.note_item(in_data_i);
      end
      if (cfg_valid_i && cfg_ready_o) begin
        model.set_buzz_len(cfg_data_i);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_out) begin
        out_stall_i <= 1'b1;
        repeat (48) @(negedge clk_i);
        hold_out = 1'b0;
      end
      out_stall_i <= !calm && ($urandom_range(0, 99) < 14);
    end
  end

  // With auto_add set, the beat is a press when the time is low and a tick otherwise; run gives its run_enable.
  task automatic send_beat(input logic mode, input logic run, input bit auto_add);
    cdtd_pkg::in_beat_t b;
    if (!calm && $urandom_range(0, 99) < 14) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    b.mode = auto_add ?
             ((model.time_now() < 150) ? cdtd_pkg::ModeAdd : cdtd_pkg::ModeTick) : mode;
    b.run_enable = run;
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
  endtask

  task automatic wait_for_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (model.pending() != 0) @(negedge clk_i);
  endtask

  task automatic write_buzz_len(input logic [cdtd_pkg::BuzzW-1:0] v);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random(input int count);
    int first;
    int pick;
    first = items_sent;
    while (items_sent - first < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_beat(cdtd_pkg::ModeTick, 1'b1, 1'b1);
        repeat ($urandom_range(30, 170)) begin
          if (items_sent - first < count) begin
            send_beat(cdtd_pkg::ModeTick, $urandom_range(0, 99) >= 3, 1'b0);
          end
        end
      end else if (pick < 80) begin
        repeat ($urandom_range(1, 12)) begin
          if (items_sent - first < count) begin
            send_beat($urandom_range(0, 99) < 10, 1'($urandom_range(0, 1)), 1'b0);
          end
        end
      end else if (pick < 95) begin
        repeat ($urandom_range(1, 20)) begin
          if (items_sent - first < count) begin
            send_beat(cdtd_pkg::ModeTick, 1'($urandom_range(0, 1)), 1'b0);
          end
        end
      end else begin
        wait_for_results();
      end
    end
  endtask

  initial begin
    model = new();
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Expiry from reset, re-arming while the buzzer sounds, then the short display ranges.
    send_beat(cdtd_pkg::ModeTick, 1'b0, 1'b0);
    send_beat(cdtd_pkg::ModeTick, 1'b1, 1'b0);
    send_beat(cdtd_pkg::ModeTick, 1'b1, 1'b0);
    send_beat(cdtd_pkg::ModeTick, 1'b0, 1'b0);
    send_beat(cdtd_pkg::ModeTick, 1'b1, 1'b0);
    send_beat(cdtd_pkg::ModeAdd, 1'b0, 1'b0);
    send_beat(cdtd_pkg::ModeTick, 1'b1, 1'b0);
    send_beat(cdtd_pkg::ModeTick, 1'b1, 1'b0);
    send_beat(cdtd_pkg::ModeAdd, 1'b1, 1'b0);
    send_beat(cdtd_pkg::ModeTick, 1'b0, 1'b0);
    send_beat(cdtd_pkg::ModeTick, 1'b1, 1'b0);
    repeat (8) send_beat(cdtd_pkg::ModeTick, 1'b1, 1'b0);
    wait_for_results();

    write_buzz_len('0);
    run_random(130);
    wait_for_results();

    write_buzz_len(6'd63);
    hold_out = 1'b1;
    run_random(130);
    wait_for_results();

    write_buzz_len(6'($urandom_range(1, 12)));
    calm = 1'b1;
    run_random(130);
    calm = 1'b0;

    // Presses through every step size up to the cap.
    repeat (45) send_beat(cdtd_pkg::ModeAdd, 1'($urandom_range(0, 1)), 1'b0);
    repeat (8) send_beat(cdtd_pkg::ModeTick, 1'($urandom_range(0, 1)), 1'b0);
    wait_for_results();
    repeat (6) @(negedge clk_i);

    if (model.failures == 0 && model.pending() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
